@@ sv/tmp_pkg.sv @@
// shared types and constants of the trapezoid motion profile generator
// used by the channel interfaces and the top level
// no dependencies
package tmp_pkg;

	// widths of the fixed channel fields
	localparam int FIELD_WIDTH = 32;
	localparam int CMD_WIDTH   = 2;
	localparam int PHASE_WIDTH = 2;
	localparam int DT_WIDTH    = 16;
	localparam int FRAC_BITS   = 16;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH  = 16;

	typedef logic [CMD_WIDTH-1:0]   cmd_t;
	typedef logic [PHASE_WIDTH-1:0] phase_t;

	// command codes
	localparam cmd_t CMD_TICK   = 2'd0;
	localparam cmd_t CMD_START  = 2'd1;
	localparam cmd_t CMD_ADJUST = 2'd2;
	localparam cmd_t CMD_RESET  = 2'd3;

	// move phases
	localparam phase_t PH_FINISHED = 2'd0;
	localparam phase_t PH_ACCEL    = 2'd1;
	localparam phase_t PH_BRAKE    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CTRL_ENABLE  = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICK_INTERVAL = 8'd1;

	localparam logic [DT_WIDTH-1:0] TICK_INTERVAL_RESET = 16'd131;

	// Q16.16 thresholds: one unit and one tenth
	localparam int Q_ONE   = 65536;
	localparam int Q_TENTH = 6554;

endpackage

@@ sv/tmp_ifs.sv @@
// valid/ready channel interfaces of the trapezoid motion profile generator:
// command transactions, result transactions and configuration writes
// depends on tmp_pkg
interface tmp_req_if import tmp_pkg::*;;
	logic                          valid;
	logic                          ready;
	cmd_t                          cmd;
	logic signed [FIELD_WIDTH-1:0] move_distance;
	logic signed [FIELD_WIDTH-1:0] top_speed;
	logic signed [FIELD_WIDTH-1:0] final_speed;
	logic signed [FIELD_WIDTH-1:0] accel_rate;
	logic signed [FIELD_WIDTH-1:0] speed_adjustment;

	modport source(output valid, cmd, move_distance, top_speed, final_speed, accel_rate,
		speed_adjustment, input ready);
	modport sink(input valid, cmd, move_distance, top_speed, final_speed, accel_rate,
		speed_adjustment, output ready);
endinterface

interface tmp_rsp_if import tmp_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [FIELD_WIDTH-1:0] speed_now;
	logic signed [FIELD_WIDTH-1:0] position_now;
	phase_t                        phase;
	logic                          finished;

	modport source(output valid, speed_now, position_now, phase, finished, input ready);
	modport sink(input valid, speed_now, position_now, phase, finished, output ready);
endinterface

interface tmp_cfg_if import tmp_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] reg_index;
	logic [CFG_DATA_WIDTH-1:0]  data;

	modport source(output valid, reg_index, data, input ready);
	modport sink(input valid, reg_index, data, output ready);
endinterface

@@ sv/tmp_mul.sv @@
// iterative unsigned shift-and-add multiplier, one multiplier bit per cycle
// WIDTH x WIDTH operands, 2*WIDTH product, done pulses when the last multiplier bit has been added
// no dependencies
module tmp_mul #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [WIDTH-1:0]     op_a,
	input  logic [WIDTH-1:0]     op_b,
	output logic                 done,
	output logic [2*WIDTH-1:0]   product
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH:0]   hi_q;
	logic [WIDTH-1:0] lo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   sum;

	// partial sum of this step
	assign sum = hi_q + ((lo_q[0]) ? {1'b0, a_q} : '0);

	// sequencing of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			a_q  <= op_a;
			hi_q <= '0;
			lo_q <= op_b;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[WIDTH:1]};
			lo_q <= {sum[0], lo_q[WIDTH-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q[WIDTH-1:0], lo_q};

endmodule

@@ sv/trapezoid_motion_profile.sv @@
// Trapezoidal velocity profile generator, Q16.16 fixed point, saturating.
// Channels: req carries a command transaction (tick, start move, adjust speed,
// reset profile) with its operands; rsp returns exactly one result transaction
// per command with speed, position, phase and a finished flag; cfg writes the
// adjust enable (index 0) and the tick interval (index 1), and is always ready.
// Write cfg only while no command is in flight.
// Throughput: one command at a time. A tick runs through one shared
// shift-and-add multiplier: a tick while accelerating needs up to five
// products, other ticks two; start is worked out in the S_START state
// before the result is loaded, adjust and reset on acceptance.
// The result sits in an output register: req is ready again as soon as the
// command is worked out, and a finished command waits there only while an
// earlier result is still held because rsp stalls.
// Reset clears speeds, positions and profile state, sets the phase to
// finished, disables adjust and sets the tick interval to 131.
// depends on tmp_pkg, tmp_ifs, tmp_mul
module trapezoid_motion_profile import tmp_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	tmp_req_if.sink    req,
	tmp_rsp_if.source  rsp,
	tmp_cfg_if.sink    cfg
);

	localparam int W  = VALUE_WIDTH;
	localparam int XW = (W > FIELD_WIDTH) ? W : FIELD_WIDTH;

	localparam logic signed [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_STEP   = 4'd2;
	localparam logic [3:0] S_TEST   = 4'd3;
	localparam logic [3:0] S_VSQ    = 4'd4;
	localparam logic [3:0] S_ESQ    = 4'd5;
	localparam logic [3:0] S_RATE   = 4'd6;
	localparam logic [3:0] S_APPLY  = 4'd7;
	localparam logic [3:0] S_RAMP   = 4'd8;
	localparam logic [3:0] S_POS_GO = 4'd9;
	localparam logic [3:0] S_POS    = 4'd10;
	localparam logic [3:0] S_FINISH = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	// saturate a sign-extended field to the value range
	function automatic logic signed [W-1:0] take_field(input logic signed [FIELD_WIDTH-1:0] x);
		logic signed [XW-1:0] e;
		e = XW'(x);
		if (e > VMAX_X) return VMAX;
		else if (e < VMIN_X) return VMIN;
		else return e[W-1:0];
	endfunction

	// low field bits of a sign-extended value
	function automatic logic signed [FIELD_WIDTH-1:0] to_field(input logic signed [W-1:0] x);
		logic signed [XW-1:0] e;
		e = XW'(x);
		return e[FIELD_WIDTH-1:0];
	endfunction

	// magnitude, the most negative value saturating to the maximum
	function automatic logic signed [W-1:0] abs_v(input logic signed [W-1:0] x);
		if (!x[W-1]) return x;
		else if (x == VMIN) return VMAX;
		else return -x;
	endfunction

	function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
		else return s[W-1:0];
	endfunction

	// configuration
	logic                enable_q;
	logic [DT_WIDTH-1:0] dt_q;

	// profile state
	logic signed [W-1:0] speed_q;
	logic signed [W-1:0] target_q;
	logic signed [W-1:0] pos_q;
	logic signed [W-1:0] end_pos_q;
	logic signed [W-1:0] end_speed_q;
	logic signed [W-1:0] accel_q;
	logic                dir_neg_q;
	phase_t              phase_q;

	// sequencer and working registers
	logic [3:0]          state_q;
	logic                brake_q;
	logic                mul_go_q;
	logic [W-1:0]        mul_a_q;
	logic [W-1:0]        mul_b_q;
	logic signed [W-1:0] dist_q;
	logic signed [W-1:0] top_q;
	logic signed [W-1:0] fin_q;
	logic signed [W-1:0] acc_in_q;
	logic signed [W-1:0] step_q;
	logic signed [W-1:0] rem_q;
	logic [2*W-1:0]      sq_q;
	logic [2*W-1:0]      diff_q;

	// result register
	logic                          out_valid_q;
	logic signed [FIELD_WIDTH-1:0] out_speed_q;
	logic signed [FIELD_WIDTH-1:0] out_pos_q;
	phase_t                        out_phase_q;

	logic                mul_done;
	logic [2*W-1:0]      mul_p;
	logic signed [W-1:0] mul_scaled;
	logic                accept;
	logic                out_load;

	// helpers of the tick datapath
	logic signed [W-1:0] rem_c;
	logic signed [W-1:0] vs_c;
	logic signed [W-1:0] ve_c;
	logic signed [W-1:0] ramp_c;
	logic signed [W-1:0] brake_tgt_c;
	logic signed [W:0]   near_c;
	logic signed [W-1:0] dm_c;
	logic signed [W-1:0] es_c;

	tmp_mul #(
		.WIDTH(W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.op_a   (mul_a_q),
		.op_b   (mul_b_q),
		.done   (mul_done),
		.product(mul_p)
	);

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign mul_scaled = mul_p[FRAC_BITS +: W];

	// braking test terms
	assign rem_c = abs_v(end_pos_q) - abs_v(pos_q);
	assign vs_c  = abs_v(speed_q);
	assign ve_c  = abs_v(end_speed_q);

	// braking target, floored at one step in the move direction
	assign brake_tgt_c = (ve_c < step_q) ? (dir_neg_q ? -step_q : step_q) : end_speed_q;

	// speed ramp toward the target with clamping
	always_comb begin
		ramp_c = speed_q;
		if (speed_q < target_q) begin
			ramp_c = add_sat(speed_q, step_q);
			if (ramp_c > target_q) ramp_c = target_q;
		end else if (speed_q > target_q) begin
			ramp_c = add_sat(speed_q, -step_q);
			if (ramp_c < target_q) ramp_c = target_q;
		end
	end

	assign near_c = {1'b0, vs_c} - {1'b0, abs_v(target_q)};

	// start command terms
	assign dm_c = abs_v(dist_q);
	assign es_c = (fin_q > top_q) ? top_q : fin_q;

	// sequencer and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enable_q    <= 1'b0;
			dt_q        <= TICK_INTERVAL_RESET;
			speed_q     <= '0;
			target_q    <= '0;
			pos_q       <= '0;
			end_pos_q   <= '0;
			end_speed_q <= '0;
			accel_q     <= '0;
			dir_neg_q   <= 1'b0;
			phase_q     <= PH_FINISHED;
			brake_q     <= 1'b0;
			mul_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;

			// configuration writes
			if (cfg.valid && cfg.ready) begin
				if (cfg.reg_index == REG_CTRL_ENABLE) enable_q <= cfg.data[0];
				else if (cfg.reg_index == REG_TICK_INTERVAL) dt_q <= cfg.data;
			end

			// result register handshake
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_TICK: begin
								mul_go_q <= 1'b1;
								state_q  <= S_STEP;
							end
							CMD_START: state_q <= S_START;
							CMD_ADJUST: begin
								if (enable_q)
									speed_q <= add_sat(speed_q, take_field(req.speed_adjustment));
								state_q <= S_DONE;
							end
							default: begin
								speed_q  <= '0;
								target_q <= '0;
								pos_q    <= '0;
								phase_q  <= PH_FINISHED;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_START: begin
					if (XW'(dm_c) < XW'(Q_ONE)) begin
						phase_q <= PH_FINISHED;
					end else begin
						dir_neg_q   <= dist_q[W-1];
						pos_q       <= '0;
						end_pos_q   <= dm_c;
						target_q    <= dist_q[W-1] ? -abs_v(top_q) : abs_v(top_q);
						end_speed_q <= dist_q[W-1] ? -abs_v(es_c) : abs_v(es_c);
						accel_q     <= abs_v(acc_in_q);
						phase_q     <= PH_ACCEL;
					end
					state_q <= S_DONE;
				end
				S_STEP: begin
					if (mul_done) begin
						brake_q <= 1'b0;
						state_q <= (phase_q == PH_ACCEL) ? S_TEST : S_RAMP;
					end
				end
				S_TEST: begin
					if (rem_c[W-1] || rem_c == '0) begin
						brake_q <= 1'b1;
						state_q <= S_APPLY;
					end else if (ve_c > vs_c) begin
						brake_q <= (accel_q == '0);
						state_q <= S_APPLY;
					end else begin
						mul_go_q <= 1'b1;
						state_q  <= S_VSQ;
					end
				end
				S_VSQ: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_ESQ;
					end
				end
				S_ESQ: begin
					if (mul_done) begin
						mul_go_q <= 1'b1;
						state_q  <= S_RATE;
					end
				end
				S_RATE: begin
					if (mul_done) begin
						brake_q <= (diff_q >= {mul_p[2*W-2:0], 1'b0});
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (brake_q) begin
						phase_q  <= PH_BRAKE;
						target_q <= brake_tgt_c;
					end
					state_q <= S_RAMP;
				end
				S_RAMP: begin
					speed_q <= ramp_c;
					state_q <= S_POS_GO;
				end
				S_POS_GO: begin
					mul_go_q <= 1'b1;
					state_q  <= S_POS;
				end
				S_POS: begin
					if (mul_done) begin
						pos_q   <= add_sat(pos_q, speed_q[W-1] ? -mul_scaled : mul_scaled);
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (phase_q == PH_BRAKE &&
						(near_c < $signed((W+1)'(Q_TENTH)) || abs_v(pos_q) >= abs_v(end_pos_q))) begin
						phase_q <= PH_FINISHED;
						speed_q <= end_speed_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand capture, multiplier operands and intermediate products
	always_ff @(posedge clk) begin
		if (accept) begin
			dist_q   <= take_field(req.move_distance);
			top_q    <= take_field(req.top_speed);
			fin_q    <= take_field(req.final_speed);
			acc_in_q <= take_field(req.accel_rate);
		end
		case (state_q)
			S_IDLE: begin
				mul_a_q <= accel_q;
				mul_b_q <= W'(dt_q);
			end
			S_STEP: begin
				if (mul_done) step_q <= mul_scaled;
			end
			S_TEST: begin
				rem_q   <= rem_c;
				mul_a_q <= vs_c;
				mul_b_q <= vs_c;
			end
			S_VSQ: begin
				if (mul_done) begin
					sq_q    <= mul_p;
					mul_a_q <= ve_c;
					mul_b_q <= ve_c;
				end
			end
			S_ESQ: begin
				if (mul_done) begin
					diff_q  <= sq_q - mul_p;
					mul_a_q <= accel_q;
					mul_b_q <= rem_q;
				end
			end
			S_POS_GO: begin
				mul_a_q <= vs_c;
				mul_b_q <= W'(dt_q);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_speed_q <= to_field(speed_q);
			out_pos_q   <= to_field(pos_q);
			out_phase_q <= phase_q;
		end
	end

	// result channel
	assign rsp.valid        = out_valid_q;
	assign rsp.speed_now    = out_speed_q;
	assign rsp.position_now = out_pos_q;
	assign rsp.phase        = out_phase_q;
	assign rsp.finished     = (out_phase_q == PH_FINISHED);

endmodule
